@@ rtl/core/mlp_inference_engine_core_defines.svh @@
// Assertion macros used by mlp_inference_engine_core.
`ifndef MLP_INFERENCE_ENGINE_CORE_DEFINES_SVH
`define MLP_INFERENCE_ENGINE_CORE_DEFINES_SVH

`ifndef SYNTH

// Same-cycle implication, checked at every rising edge outside reset.
`define MLP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define MLP_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define MLP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define MLP_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

@@ rtl/core/mlp_pkg.sv @@
`default_nettype none

package mlp_pkg;

	localparam int DATA_W = 16;
	localparam int PRED_W = 24;
	localparam int FRAC_W = 12;

	// Request commands.
	localparam logic [1:0] CMD_WEIGHT  = 2'd0;
	localparam logic [1:0] CMD_BIAS    = 2'd1;
	localparam logic [1:0] CMD_FEATURE = 2'd2;

	// Configuration register indexes.
	localparam logic [0:0] CFG_ACTIVE_WIDTH = 1'b0;
	localparam logic [0:0] CFG_LAYER_COUNT  = 1'b1;

	localparam logic [4:0] ACTIVE_WIDTH_RST = 5'd16;
	localparam logic [3:0] LAYER_COUNT_RST  = 4'd1;

	// Activation window in Q.24: kept when strictly between -1.0 and 2.0.
	localparam int ACT_LO = -16777216;
	localparam int ACT_HI = 33554432;

	localparam int PRED_MAX = 8388607;
	localparam int PRED_MIN = -8388608;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MAC,
		ST_DRAIN,
		ST_SUM,
		ST_SUM_WAIT,
		ST_RESULT
	} eng_state_t;

	// Control that travels with one multiply-accumulate issue.
	typedef struct packed {
		logic valid;
		logic first;
		logic last;
		logic from_feat;
		logic bank;
	} mac_tag_t;

endpackage

`default_nettype wire

@@ rtl/core/mlp_param_mem.sv @@
`default_nettype none

module mlp_param_mem
	import mlp_pkg::*;
#(
	parameter int MAX_WIDTH = 16,
	parameter int MAX_DEPTH_LAYERS = 8,
	localparam int WDEPTH = MAX_DEPTH_LAYERS * MAX_WIDTH * MAX_WIDTH,
	localparam int BDEPTH = MAX_DEPTH_LAYERS * MAX_WIDTH,
	localparam int WAW = (WDEPTH > 1) ? $clog2(WDEPTH) : 1,
	localparam int BAW = (BDEPTH > 1) ? $clog2(BDEPTH) : 1
) (
	input  wire logic                     clk,
	input  wire logic                     w_we,
	input  wire logic [WAW-1:0]           w_waddr,
	input  wire logic signed [DATA_W-1:0] w_wdata,
	input  wire logic [WAW-1:0]           w_raddr,
	output logic signed [DATA_W-1:0]      w_rdata,
	input  wire logic                     b_we,
	input  wire logic [BAW-1:0]           b_waddr,
	input  wire logic signed [DATA_W-1:0] b_wdata,
	input  wire logic [BAW-1:0]           b_raddr,
	output logic signed [DATA_W-1:0]      b_rdata
);

	logic [DATA_W-1:0] weight_mem [WDEPTH];
	logic [DATA_W-1:0] bias_mem [BDEPTH];

	always_ff @(posedge clk) begin
		if (w_we) begin
			weight_mem[w_waddr] <= w_wdata;
		end
		w_rdata <= weight_mem[w_raddr];
	end

	always_ff @(posedge clk) begin
		if (b_we) begin
			bias_mem[b_waddr] <= b_wdata;
		end
		b_rdata <= bias_mem[b_raddr];
	end

endmodule

`default_nettype wire

@@ rtl/core/mlp_value_mem.sv @@
`default_nettype none

module mlp_value_mem
	import mlp_pkg::*;
#(
	parameter int MAX_WIDTH = 16,
	localparam int IW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
	localparam int VAW = $clog2(2 * MAX_WIDTH)
) (
	input  wire logic                     clk,
	input  wire logic                     f_we,
	input  wire logic [IW-1:0]            f_waddr,
	input  wire logic signed [DATA_W-1:0] f_wdata,
	input  wire logic [IW-1:0]            f_raddr,
	output logic signed [DATA_W-1:0]      f_rdata,
	input  wire logic                     v_we,
	input  wire logic [VAW-1:0]           v_waddr,
	input  wire logic signed [DATA_W-1:0] v_wdata,
	input  wire logic [VAW-1:0]           v_raddr,
	output logic signed [DATA_W-1:0]      v_rdata
);

	// Features, and two banks of node values that alternate per layer.
	logic [DATA_W-1:0] feature_mem [MAX_WIDTH];
	logic [DATA_W-1:0] value_mem [2 * MAX_WIDTH];

	always_ff @(posedge clk) begin
		if (f_we) begin
			feature_mem[f_waddr] <= f_wdata;
		end
		f_rdata <= feature_mem[f_raddr];
	end

	always_ff @(posedge clk) begin
		if (v_we) begin
			value_mem[v_waddr] <= v_wdata;
		end
		v_rdata <= value_mem[v_raddr];
	end

endmodule

`default_nettype wire

@@ rtl/core/mlp_mac_unit.sv @@
`default_nettype none

module mlp_mac_unit
	import mlp_pkg::*;
#(
	parameter int MAX_WIDTH = 16,
	localparam int IW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
	localparam int AW = 2 * DATA_W + $clog2(MAX_WIDTH + 1) + 1
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire mac_tag_t                 tag_s1,
	input  wire logic [IW-1:0]            node_s1,
	input  wire logic signed [DATA_W-1:0] w_rdata,
	input  wire logic signed [DATA_W-1:0] b_rdata,
	input  wire logic signed [DATA_W-1:0] f_rdata,
	input  wire logic signed [DATA_W-1:0] v_rdata,
	output logic                          vw_we,
	output logic                          vw_bank,
	output logic [IW-1:0]                 vw_node,
	output logic signed [DATA_W-1:0]      vw_data,
	output logic                          idle
);

	localparam logic signed [AW-1:0] LIM_LO = AW'(ACT_LO);
	localparam logic signed [AW-1:0] LIM_HI = AW'(ACT_HI);

	mac_tag_t                   tag_s2, tag_s3;
	logic [IW-1:0]              node_s2, node_s3, node_s4;
	logic signed [DATA_W-1:0]   prev;
	logic signed [2*DATA_W-1:0] prod;
	logic signed [2*DATA_W-1:0] prod_s3;
	logic signed [DATA_W-1:0]   bias_s3;
	logic signed [AW-1:0]       acc_q, acc_base, acc_sum, fin_acc_s4;
	logic                       fin_v_s4, bank_s4;

	// Memory data for the issued request arrives in the cycle after the issue.
	assign prev = tag_s2.from_feat ? f_rdata : v_rdata;
	assign prod = w_rdata * prev;

	assign acc_base = tag_s3.first ? (AW'(bias_s3) <<< FRAC_W) : acc_q;
	assign acc_sum  = acc_base + AW'(prod_s3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s2   <= '0;
			tag_s3   <= '0;
			fin_v_s4 <= 1'b0;
		end else begin
			tag_s2   <= tag_s1;
			tag_s3   <= tag_s2;
			fin_v_s4 <= tag_s3.valid && tag_s3.last;
		end
	end

	always_ff @(posedge clk) begin
		node_s2 <= node_s1;
		node_s3 <= node_s2;
		prod_s3 <= prod;
		bias_s3 <= b_rdata;
		if (tag_s3.valid) begin
			acc_q <= acc_sum;
		end
		if (tag_s3.valid && tag_s3.last) begin
			fin_acc_s4 <= acc_sum;
			node_s4    <= node_s3;
			bank_s4    <= tag_s3.bank;
		end
	end

	// Activation: floor to Q4.12 inside the window, zero outside it.
	always_comb begin
		vw_we   = fin_v_s4;
		vw_bank = bank_s4;
		vw_node = node_s4;
		if (fin_acc_s4 > LIM_LO && fin_acc_s4 < LIM_HI) begin
			vw_data = fin_acc_s4[FRAC_W+DATA_W-1:FRAC_W];
		end else begin
			vw_data = '0;
		end
	end

	assign idle = !tag_s2.valid && !tag_s3.valid && !fin_v_s4;

endmodule

`default_nettype wire

@@ rtl/core/mlp_inference_engine_core.sv @@
// Fixed-point forward pass of a square, fully connected perceptron. Every
// request is taken when start is high and busy is low; a weight, bias or
// feature write finishes in that cycle and leaves busy low, so writes can
// stream at one per cycle. A request marked final_feature performs its own
// write and then starts the pass: busy rises and one result follows on
// prediction_sum, marked by done for exactly one cycle. The receiver cannot
// stall, so done must be sampled when it appears. The time of a pass is set
// by the single multiply-accumulate unit and the one read port of the
// weight memory, which feeds one product per cycle. Each layer waits in
// the drain state for the last node value to land in the value memory
// before the next layer reads it. Memories need no clearing after reset;
// a table entry must be written before a pass reads it. Configuration
// writes are always taken (cfg_ready is high) and must only be issued
// while the block is idle.
`default_nettype none
`include "mlp_inference_engine_core_defines.svh"

module mlp_inference_engine_core
	import mlp_pkg::*;
#(
	parameter int MAX_WIDTH = 16,
	parameter int MAX_DEPTH_LAYERS = 8
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	output logic                          busy,
	input  wire logic [1:0]               cmd,
	input  wire logic [2:0]               layer_sel,
	input  wire logic [3:0]               node_sel,
	input  wire logic [3:0]               input_sel,
	input  wire logic signed [DATA_W-1:0] data_value,
	input  wire logic                     final_feature,
	output logic                          done,
	output logic signed [PRED_W-1:0]      prediction_sum,
	input  wire logic                     cfg_valid,
	output logic                          cfg_ready,
	input  wire logic [0:0]               cfg_index,
	input  wire logic [4:0]               cfg_data
);

	localparam int IW     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int CW     = $clog2(MAX_WIDTH + 1);
	localparam int LIW    = (MAX_DEPTH_LAYERS > 1) ? $clog2(MAX_DEPTH_LAYERS) : 1;
	localparam int LCW    = $clog2(MAX_DEPTH_LAYERS + 1);
	localparam int WDEPTH = MAX_DEPTH_LAYERS * MAX_WIDTH * MAX_WIDTH;
	localparam int BDEPTH = MAX_DEPTH_LAYERS * MAX_WIDTH;
	localparam int WAW    = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
	localparam int BAW    = (BDEPTH > 1) ? $clog2(BDEPTH) : 1;
	localparam int VAW    = $clog2(2 * MAX_WIDTH);
	localparam int SUM_RAW = DATA_W + CW + 1;
	localparam int SUMW   = (SUM_RAW > PRED_W + 1) ? SUM_RAW : PRED_W + 1;

	localparam logic signed [SUMW-1:0] SUM_MAX = SUMW'(PRED_MAX);
	localparam logic signed [SUMW-1:0] SUM_MIN = SUMW'(PRED_MIN);

	// Configuration registers.
	logic [4:0] active_width_q;
	logic [3:0] layer_count_q;

	// Sequencer state and loop counters.
	eng_state_t state_q, state_d;
	logic [LIW-1:0] layer_q;
	logic [IW-1:0]  node_q, in_q;
	logic [CW-1:0]  w_eff, w_eff_q;
	logic [LCW-1:0] nl_eff, nl_q;
	logic [WAW-1:0] lbase_q, wrow_q;
	logic [BAW-1:0] brow_q;
	logic           last_in, last_node, last_layer;

	logic req_acc, pass_start;

	// Memory ports.
	logic                     w_we, b_we, f_we;
	logic [WAW-1:0]           w_waddr, w_raddr;
	logic [BAW-1:0]           b_waddr, b_raddr;
	logic [IW-1:0]            f_waddr;
	logic [VAW-1:0]           v_waddr, v_raddr;
	logic signed [DATA_W-1:0] w_rdata, b_rdata, f_rdata, v_rdata;

	// Multiply-accumulate unit.
	mac_tag_t                 tag_s1;
	logic                     vw_we, vw_bank, mac_idle;
	logic [IW-1:0]            vw_node;
	logic signed [DATA_W-1:0] vw_data;

	// Final sum and result.
	logic                     sum_v_s2;
	logic signed [SUMW-1:0]   sum_q;
	logic signed [PRED_W-1:0] pred_q;
	logic                     done_q;

	assign busy       = (state_q != ST_IDLE);
	assign req_acc    = start && !busy;
	assign pass_start = req_acc && final_feature;
	assign cfg_ready  = 1'b1;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_width_q <= ACTIVE_WIDTH_RST;
			layer_count_q  <= LAYER_COUNT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_ACTIVE_WIDTH: active_width_q <= cfg_data;
				CFG_LAYER_COUNT:  layer_count_q  <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// Width beyond the array acts as the full array; a layer count of zero
	// acts as one, and a count beyond the array as the full depth.
	assign w_eff = (int'(active_width_q) > MAX_WIDTH) ? CW'(MAX_WIDTH) : CW'(active_width_q);

	always_comb begin
		if (layer_count_q == '0) begin
			nl_eff = LCW'(1);
		end else if (int'(layer_count_q) > MAX_DEPTH_LAYERS) begin
			nl_eff = LCW'(MAX_DEPTH_LAYERS);
		end else begin
			nl_eff = LCW'(layer_count_q);
		end
	end

	// Table writes from requests. A selector outside its table drops the write;
	// an unused command writes nothing.
	always_comb begin
		w_we = req_acc && (cmd == CMD_WEIGHT) && (int'(layer_sel) < MAX_DEPTH_LAYERS)
			&& (int'(node_sel) < MAX_WIDTH) && (int'(input_sel) < MAX_WIDTH);
		b_we = req_acc && (cmd == CMD_BIAS) && (int'(layer_sel) < MAX_DEPTH_LAYERS)
			&& (int'(node_sel) < MAX_WIDTH);
		f_we = req_acc && (cmd == CMD_FEATURE) && (int'(input_sel) < MAX_WIDTH);
		w_waddr = WAW'((int'(layer_sel) * MAX_WIDTH + int'(node_sel)) * MAX_WIDTH
			+ int'(input_sel));
		b_waddr = BAW'(int'(layer_sel) * MAX_WIDTH + int'(node_sel));
		f_waddr = IW'(input_sel);
	end

	assign last_in    = (CW'(in_q) + CW'(1)) == w_eff_q;
	assign last_node  = (CW'(node_q) + CW'(1)) == w_eff_q;
	assign last_layer = (LCW'(layer_q) + LCW'(1)) == nl_q;

	// Read addresses. Layer l reads the bank written by layer l-1 and writes
	// the other one; the final sum reads the bank of the last layer.
	assign w_raddr = wrow_q + WAW'(in_q);
	assign b_raddr = brow_q + BAW'(node_q);

	always_comb begin
		if (state_q == ST_SUM) begin
			v_raddr = (layer_q[0] ? VAW'(MAX_WIDTH) : VAW'(0)) + VAW'(in_q);
		end else begin
			v_raddr = (layer_q[0] ? VAW'(0) : VAW'(MAX_WIDTH)) + VAW'(in_q);
		end
		v_waddr = (vw_bank ? VAW'(MAX_WIDTH) : VAW'(0)) + VAW'(vw_node);
	end

	mlp_param_mem #(
		.MAX_WIDTH        (MAX_WIDTH),
		.MAX_DEPTH_LAYERS (MAX_DEPTH_LAYERS)
	) u_param_mem (
		.clk     (clk),
		.w_we    (w_we),
		.w_waddr (w_waddr),
		.w_wdata (data_value),
		.w_raddr (w_raddr),
		.w_rdata (w_rdata),
		.b_we    (b_we),
		.b_waddr (b_waddr),
		.b_wdata (data_value),
		.b_raddr (b_raddr),
		.b_rdata (b_rdata)
	);

	mlp_value_mem #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_value_mem (
		.clk     (clk),
		.f_we    (f_we),
		.f_waddr (f_waddr),
		.f_wdata (data_value),
		.f_raddr (in_q),
		.f_rdata (f_rdata),
		.v_we    (vw_we),
		.v_waddr (v_waddr),
		.v_wdata (vw_data),
		.v_raddr (v_raddr),
		.v_rdata (v_rdata)
	);

	mlp_mac_unit #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_mac_unit (
		.clk     (clk),
		.arst_n  (arst_n),
		.tag_s1  (tag_s1),
		.node_s1 (node_q),
		.w_rdata (w_rdata),
		.b_rdata (b_rdata),
		.f_rdata (f_rdata),
		.v_rdata (v_rdata),
		.vw_we   (vw_we),
		.vw_bank (vw_bank),
		.vw_node (vw_node),
		.vw_data (vw_data),
		.idle    (mac_idle)
	);

	// Sequencer: one product is issued per cycle in the MAC state; nodes of a
	// layer follow back to back, and the drain state holds the next layer
	// until the last node value of this one has been written.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d          = state_q;
		tag_s1           = '0;
		case (state_q)
			ST_IDLE: begin
				if (pass_start) begin
					// With no active nodes the sum is zero straight away.
					state_d = (w_eff == '0) ? ST_RESULT : ST_MAC;
				end
			end
			ST_MAC: begin
				tag_s1.valid     = 1'b1;
				tag_s1.first     = (in_q == '0);
				tag_s1.last      = last_in;
				tag_s1.from_feat = (layer_q == '0);
				tag_s1.bank      = layer_q[0];
				if (last_in && last_node) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (mac_idle) begin
					state_d = last_layer ? ST_SUM : ST_MAC;
				end
			end
			ST_SUM: begin
				if (last_in) begin
					state_d = ST_SUM_WAIT;
				end
			end
			ST_SUM_WAIT: state_d = ST_RESULT;
			ST_RESULT:   state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	// Loop counters and table row bases.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (pass_start) begin
					w_eff_q <= w_eff;
					nl_q    <= nl_eff;
					layer_q <= '0;
					node_q  <= '0;
					in_q    <= '0;
					lbase_q <= '0;
					wrow_q  <= '0;
					brow_q  <= '0;
				end
			end
			ST_MAC: begin
				if (last_in) begin
					in_q   <= '0;
					node_q <= IW'(node_q + IW'(1));
					wrow_q <= wrow_q + WAW'(MAX_WIDTH);
				end else begin
					in_q <= IW'(in_q + IW'(1));
				end
			end
			ST_DRAIN: begin
				if (mac_idle) begin
					node_q <= '0;
					in_q   <= '0;
					if (!last_layer) begin
						layer_q <= LIW'(layer_q + LIW'(1));
						lbase_q <= lbase_q + WAW'(MAX_WIDTH * MAX_WIDTH);
						wrow_q  <= lbase_q + WAW'(MAX_WIDTH * MAX_WIDTH);
						brow_q  <= brow_q + BAW'(MAX_WIDTH);
					end
				end
			end
			ST_SUM: begin
				in_q <= IW'(in_q + IW'(1));
			end
			default: ;
		endcase
	end

	// Final sum of the last layer's values, one value per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_v_s2 <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			sum_v_s2 <= (state_q == ST_SUM);
			done_q   <= (state_q == ST_RESULT);
		end
	end

	always_ff @(posedge clk) begin
		if (pass_start) begin
			sum_q <= '0;
		end else if (sum_v_s2) begin
			sum_q <= sum_q + SUMW'(v_rdata);
		end
		if (state_q == ST_RESULT) begin
			if (sum_q > SUM_MAX) begin
				pred_q <= PRED_W'(PRED_MAX);
			end else if (sum_q < SUM_MIN) begin
				pred_q <= PRED_W'(PRED_MIN);
			end else begin
				pred_q <= sum_q[PRED_W-1:0];
			end
		end
	end

	assign done           = done_q;
	assign prediction_sum = pred_q;

	// The result strobe comes only after the pass has ended.
	`MLP_ASSERT_IMP(a_done_idle, clk, arst_n, done, !busy, "result strobe while busy")
	// A final request always starts a pass.
	`MLP_ASSERT_NXT(a_final_busy, clk, arst_n, pass_start, busy, "final request did not start a pass")
	// A plain write request neither starts a pass nor yields a result.
	`MLP_ASSERT_NXT(a_write_quiet, clk, arst_n, req_acc && !final_feature, !busy && !done, "write request started a pass")
	// Node values are written only while a layer is computed or drained.
	`MLP_ASSERT_IMP(a_vw_phase, clk, arst_n, vw_we, state_q == ST_MAC || state_q == ST_DRAIN, "node value written outside a layer")

endmodule

`default_nettype wire

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 100ps

// Self-checking bench for the fixed-point perceptron core. Requests are
// driven on the falling clock edge and the core's outputs are sampled on
// the rising edge, so neither side races the other. Every accepted request
// is replayed into a local copy of the weight, bias and feature tables; a
// request marked final_feature also runs the forward pass on that copy and
// queues the expected prediction_sum. The checker pops one expectation for
// every done pulse.
module tb_top;
	import mlp_pkg::*;

	localparam int TB_MAX_W      = 16;
	localparam int TB_MAX_L      = 8;
	localparam int DEEP_W        = 4;
	localparam int RANDOM_ITEMS  = 450;
	localparam int STALL_LIMIT   = 20000;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	logic                     clk;
	logic                     arst_n;
	logic                     start;
	logic                     busy;
	logic [1:0]               cmd;
	logic [2:0]               layer_sel;
	logic [3:0]               node_sel;
	logic [3:0]               input_sel;
	logic signed [DATA_W-1:0] data_value;
	logic                     final_feature;
	logic                     done;
	logic signed [PRED_W-1:0] prediction_sum;
	logic                     cfg_valid;
	logic                     cfg_ready;
	logic [0:0]               cfg_index;
	logic [4:0]               cfg_data;

	// Local image of the core's tables and registers.
	shortint weight_tbl [TB_MAX_L*TB_MAX_W*TB_MAX_W];
	shortint bias_tbl [TB_MAX_L*TB_MAX_W];
	shortint feature_tbl [TB_MAX_W];
	logic [4:0] width_reg;
	logic [3:0] layers_reg;

	// Expected prediction sums, oldest first.
	logic signed [PRED_W-1:0] pending_sums [$];
	logic signed [PRED_W-1:0] wanted_sum;

	int fail_count;
	int sums_checked;
	int counted_requests;
	int idle_cycles;
	bit no_gap;

	mlp_inference_engine_core DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.cmd           (cmd),
		.layer_sel     (layer_sel),
		.node_sel      (node_sel),
		.input_sel     (input_sel),
		.data_value    (data_value),
		.final_feature (final_feature),
		.done          (done),
		.prediction_sum(prediction_sum),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Forward-pass predictor.
	// ------------------------------------------------------------------

	// Widths above the table size act as the table size.
	function automatic int eff_width();
		return (width_reg > TB_MAX_W) ? TB_MAX_W : int'(width_reg);
	endfunction

	// A layer count of zero acts as one; above the table depth it saturates.
	function automatic int eff_depth();
		if (layers_reg < 1)
			return 1;
		return (layers_reg > TB_MAX_L) ? TB_MAX_L : int'(layers_reg);
	endfunction

	// The node keeps its Q.24 sum only when it lies strictly inside (-1, 2).
	// A kept sum is floored to Q4.12, which an arithmetic shift does.
	function automatic shortint clip_node(input longint acc);
		if (acc <= -(longint'(1) << 24) || acc >= (longint'(2) << 24))
			return shortint'(0);
		return shortint'(acc >>> 12);
	endfunction

	function automatic logic signed [PRED_W-1:0] forward_pass();
		int width;
		int depth;
		int l;
		int n;
		int i;
		shortint node_vals [TB_MAX_W];
		shortint next_vals [TB_MAX_W];
		longint acc;
		longint total;
		width = eff_width();
		depth = eff_depth();
		for (l = 0; l < depth; l++) begin
			for (n = 0; n < width; n++) begin
				acc = longint'(bias_tbl[l*TB_MAX_W + n]) * 4096;
				for (i = 0; i < width; i++) begin
					acc += longint'(weight_tbl[(l*TB_MAX_W + n)*TB_MAX_W + i]) *
						longint'((l == 0) ? feature_tbl[i] : node_vals[i]);
				end
				next_vals[n] = clip_node(acc);
			end
			for (n = 0; n < width; n++)
				node_vals[n] = next_vals[n];
		end
		total = 0;
		for (n = 0; n < width; n++)
			total += node_vals[n];
		if (total > PRED_MAX)
			total = PRED_MAX;
		if (total < PRED_MIN)
			total = PRED_MIN;
		return total[PRED_W-1:0];
	endfunction

	// Apply one accepted request to the table image, then run the pass if the
	// request carries the final mark. Every selector is in range by width.
	task automatic apply_request(input logic [1:0] c, input logic [2:0] ls,
			input logic [3:0] ns, input logic [3:0] is,
			input logic signed [DATA_W-1:0] dv, input logic fin);
		case (c)
			CMD_WEIGHT:  weight_tbl[{ls, ns, is}] = dv;
			CMD_BIAS:    bias_tbl[{ls, ns}] = dv;
			CMD_FEATURE: feature_tbl[is] = dv;
			default: ;
		endcase
		if (c != CMD_UNUSED)
			counted_requests++;
		if (fin)
			pending_sums.push_back(forward_pass());
	endtask

	// ------------------------------------------------------------------
	// Request driver. All tasks below are entered at a falling edge.
	// ------------------------------------------------------------------

	task automatic pause_requests(input int cycles);
		start = 1'b0;
		repeat (cycles) @(negedge clk);
	endtask

	// Mostly back-to-back, sometimes a short gap, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_gap || r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// Present one request and hold it until the core takes it. When no gap
	// follows, start simply stays high for the next request.
	task automatic send_request(input logic [1:0] c, input logic [2:0] ls,
			input logic [3:0] ns, input logic [3:0] is,
			input logic signed [DATA_W-1:0] dv, input logic fin);
		int gap;
		start = 1'b1;
		cmd = c;
		layer_sel = ls;
		node_sel = ns;
		input_sel = is;
		data_value = dv;
		final_feature = fin;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		apply_request(c, ls, ns, is, dv, fin);
		@(negedge clk);
		gap = pick_gap();
		if (gap > 0)
			pause_requests(gap);
	endtask

	// Hold off new requests until every predicted sum has arrived and the
	// core has dropped busy, then leave a margin before returning.
	task automatic wait_idle();
		start = 1'b0;
		do
			@(posedge clk);
		while (pending_sums.size() != 0 || busy !== 1'b0);
		@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// Only ever called with the core idle.
	task automatic write_config(input logic [0:0] idx, input logic [4:0] val);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		do
			@(posedge clk);
		while (cfg_ready !== 1'b1);
		if (idx == CFG_ACTIVE_WIDTH)
			width_reg = val;
		else
			layers_reg = val[3:0];
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic set_shape(input logic [4:0] width, input logic [4:0] layers);
		wait_idle();
		write_config(CFG_ACTIVE_WIDTH, width);
		write_config(CFG_LAYER_COUNT, layers);
	endtask

	// Weights are kept small most of the time so that sums land inside the
	// activation window often enough; the rest covers the full range.
	function automatic logic signed [DATA_W-1:0] rand_weight();
		int r;
		int v;
		r = $urandom_range(0, 9);
		if (r < 7)
			v = $urandom_range(0, 600) - 300;
		else if (r < 9)
			v = $urandom_range(0, 4096) - 2048;
		else
			v = $urandom_range(0, 65535);
		return v[DATA_W-1:0];
	endfunction

	// Biases and features mostly within the range a node value can take.
	function automatic logic signed [DATA_W-1:0] rand_value();
		int v;
		if ($urandom_range(0, 7) != 0)
			v = $urandom_range(0, 12287) - 4096;
		else
			v = $urandom_range(0, 65535);
		return v[DATA_W-1:0];
	endfunction

	// ------------------------------------------------------------------
	// Tests.
	// ------------------------------------------------------------------

	// Layer 0 is written in full and every deeper layer over its first DEEP_W
	// nodes and inputs. Shapes wider than DEEP_W therefore run one layer only,
	// so no pass can read an entry that was never written.
	task automatic test_load_tables();
		int l;
		int n;
		int i;
		int span;
		for (l = 0; l < TB_MAX_L; l++) begin
			span = (l == 0) ? TB_MAX_W : DEEP_W;
			for (n = 0; n < span; n++)
				for (i = 0; i < span; i++)
					send_request(CMD_WEIGHT, 3'(l), 4'(n), 4'(i), rand_weight(), 1'b0);
		end
		for (l = 0; l < TB_MAX_L; l++) begin
			span = (l == 0) ? TB_MAX_W : DEEP_W;
			for (n = 0; n < span; n++)
				send_request(CMD_BIAS, 3'(l), 4'(n), 4'd0, rand_value(), 1'b0);
		end
		for (i = 0; i < TB_MAX_W; i++)
			send_request(CMD_FEATURE, 3'd0, 4'd0, 4'(i), rand_value(), 1'b0);
	endtask

	// A pass with the registers still at their reset values.
	task automatic test_reset_shape();
		send_request(CMD_FEATURE, 3'd7, 4'd15, 4'd15, 16'sd0, 1'b1);
	endtask

	// One node, one layer: hit both window edges exactly, the value just
	// inside each, the largest products of both signs, the unused command,
	// and the final mark on weight and bias writes.
	task automatic test_activation_edges();
		set_shape(5'd1, 5'd1);
		send_request(CMD_WEIGHT, 3'd0, 4'd0, 4'd0, 16'sd4096, 1'b0);
		send_request(CMD_BIAS, 3'd0, 4'd0, 4'd0, 16'sd4096, 1'b0);
		// Bias 1.0 plus 1.0 times 1.0 sits exactly on the upper edge.
		send_request(CMD_FEATURE, 3'd0, 4'd0, 4'd0, 16'sd4096, 1'b1);
		// One LSB less of bias stays just under 2.0 and is kept.
		send_request(CMD_BIAS, 3'd0, 4'd0, 4'd0, 16'sd4095, 1'b1);
		// Bias -1.0 plus the smallest product is just above -1 and floors
		// to -1.0.
		send_request(CMD_BIAS, 3'd0, 4'd0, 4'd0, -16'sd4096, 1'b0);
		send_request(CMD_WEIGHT, 3'd0, 4'd0, 4'd0, 16'sd1, 1'b0);
		send_request(CMD_FEATURE, 3'd0, 4'd0, 4'd0, 16'sd1, 1'b1);
		// With a zero weight the sum is exactly -1.0 and is dropped.
		send_request(CMD_WEIGHT, 3'd0, 4'd0, 4'd0, 16'sd0, 1'b1);
		send_request(CMD_WEIGHT, 3'd0, 4'd0, 4'd0, -16'sd32768, 1'b0);
		send_request(CMD_FEATURE, 3'd0, 4'd0, 4'd0, -16'sd32768, 1'b1);
		send_request(CMD_FEATURE, 3'd0, 4'd0, 4'd0, 16'sd32767, 1'b1);
		// The unused command writes nothing but still runs the pass.
		send_request(CMD_UNUSED, 3'd7, 4'd15, 4'd15, -16'sd1, 1'b1);
		send_request(CMD_WEIGHT, 3'd7, 4'd15, 4'd15, 16'sd32767, 1'b0);
		send_request(CMD_BIAS, 3'd7, 4'd15, 4'd15, -16'sd32768, 1'b0);
	endtask

	// Register values outside the useful range, the full width and the
	// full depth.
	task automatic test_shape_extremes();
		set_shape(5'd0, 5'd0);
		send_request(CMD_FEATURE, 3'd0, 4'd0, 4'd3, rand_value(), 1'b1);
		set_shape(5'd31, 5'd1);
		send_request(CMD_FEATURE, 3'd0, 4'd0, 4'd15, rand_value(), 1'b1);
		set_shape(5'd4, 5'd15);
		send_request(CMD_FEATURE, 3'd0, 4'd0, 4'd2, rand_value(), 1'b1);
		set_shape(5'd16, 5'd1);
		send_request(CMD_FEATURE, 3'd0, 4'd0, 4'd0, rand_value(), 1'b1);
		set_shape(5'd4, 5'd8);
		send_request(CMD_FEATURE, 3'd0, 4'd0, 4'd1, rand_value(), 1'b1);
		set_shape(5'd1, 5'd8);
		send_request(CMD_BIAS, 3'd5, 4'd0, 4'd0, rand_value(), 1'b1);
	endtask

	// The sender stops until every outstanding result is in, then resumes.
	task automatic test_drain_pause();
		set_shape(5'd4, 5'd2);
		send_request(CMD_FEATURE, 3'd0, 4'd0, 4'd2, rand_value(), 1'b1);
		wait_idle();
		send_request(CMD_FEATURE, 3'd0, 4'd0, 4'd1, rand_value(), 1'b1);
	endtask

	// Mostly small shapes to keep passes short, with the extremes in the mix.
	// A shape wider than DEEP_W keeps a single layer.
	task automatic random_shape();
		int r;
		logic [4:0] width;
		logic [4:0] layers;
		r = $urandom_range(0, 9);
		if (r < 6)
			width = 5'($urandom_range(1, 6));
		else if (r < 8)
			width = 5'($urandom_range(7, 16));
		else if (r == 8)
			width = $urandom_range(0, 1) ? 5'd16 : 5'd0;
		else
			width = 5'($urandom_range(17, 31));
		if (width > DEEP_W) begin
			layers = 5'($urandom_range(0, 1));
		end else begin
			r = $urandom_range(0, 9);
			if (r < 6)
				layers = 5'($urandom_range(1, 3));
			else if (r < 8)
				layers = 5'($urandom_range(4, 8));
			else if (r == 8)
				layers = $urandom_range(0, 1) ? 5'd8 : 5'd0;
			else
				layers = 5'($urandom_range(9, 31));
		end
		set_shape(width, layers);
	endtask

	// Random inference frames: update a few weights and biases in the active
	// region, deliver a full feature vector and mark the last one. A small
	// share of frames is noise with every field random.
	task automatic test_random_frames();
		int base;
		int width;
		int depth;
		int updates;
		int k;
		int i;
		base = counted_requests;
		while (counted_requests - base < RANDOM_ITEMS) begin
			if ($urandom_range(0, 4) == 0)
				random_shape();
			no_gap = ($urandom_range(0, 3) == 0);
			width = eff_width();
			depth = eff_depth();
			if ($urandom_range(0, 9) < 8) begin
				updates = (width == 0) ? 0 : $urandom_range(0, 12);
				for (k = 0; k < updates; k++) begin
					if ($urandom_range(0, 9) < 7)
						send_request(CMD_WEIGHT, 3'($urandom_range(0, depth - 1)),
							4'($urandom_range(0, width - 1)),
							4'($urandom_range(0, width - 1)), rand_weight(), 1'b0);
					else
						send_request(CMD_BIAS, 3'($urandom_range(0, depth - 1)),
							4'($urandom_range(0, width - 1)), 4'($urandom_range(0, 15)),
							rand_value(), 1'b0);
				end
				if (width == 0) begin
					send_request(CMD_FEATURE, 3'($urandom_range(0, 7)),
						4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
						rand_value(), 1'b1);
				end else begin
					for (i = 0; i < width; i++)
						send_request(CMD_FEATURE, 3'($urandom_range(0, 7)),
							4'($urandom_range(0, 15)), 4'(i), rand_value(),
							i == width - 1);
				end
			end else begin
				updates = $urandom_range(1, 6);
				for (k = 0; k < updates; k++)
					send_request(2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)),
						4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
						16'($urandom_range(0, 65535)), $urandom_range(0, 3) == 0);
			end
		end
		no_gap = 1'b0;
	endtask

	// ------------------------------------------------------------------
	// Result checker: each done pulse is matched against the oldest
	// expectation. The core cannot be stalled, so every strobe counts.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n && done === 1'b1) begin
			if (pending_sums.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual prediction_sum=%0d",
					$time, prediction_sum);
				fail_count++;
			end else begin
				wanted_sum = pending_sums.pop_front();
				sums_checked++;
				if (prediction_sum !== wanted_sum) begin
					$display("%0t: prediction_sum mismatch, expected %0d, actual %0d",
						$time, wanted_sum, prediction_sum);
					fail_count++;
				end
			end
		end
	end

	// Watchdog: any handshake or result restarts the count. The longest
	// honest silence is one pass.
	always @(posedge clk) begin
		if (!arst_n || (start && busy === 1'b0) || (cfg_valid && cfg_ready === 1'b1)
				|| done === 1'b1) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
			$display("[FAIL] regression broken");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// ------------------------------------------------------------------
	// Main sequence.
	// ------------------------------------------------------------------
	initial begin
		fail_count = 0;
		sums_checked = 0;
		counted_requests = 0;
		idle_cycles = 0;
		no_gap = 1'b0;
		width_reg = ACTIVE_WIDTH_RST;
		layers_reg = LAYER_COUNT_RST;
		arst_n = 1'b0;
		start = 1'b0;
		cmd = CMD_WEIGHT;
		layer_sel = '0;
		node_sel = '0;
		input_sel = '0;
		data_value = '0;
		final_feature = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_ACTIVE_WIDTH;
		cfg_data = '0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_load_tables();
		test_reset_shape();
		test_activation_edges();
		test_shape_extremes();
		test_drain_pause();
		test_random_frames();

		// Let the last pass finish, then watch a little longer for strays.
		wait_idle();
		repeat (50) @(negedge clk);
		if (fail_count == 0 && pending_sums.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
